/* rtl/core/usbrw_pkg.sv */
`timescale 1ns / 1ps
// Package for the USB remote-wake controller: opcodes, phases, item and state types.
// No dependencies; used by usbrw_in_if, usbrw_step, the top level, the checker and the testbench.

package usbrw_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LEN_W    = 10;
    localparam int unsigned BTN_W    = 24;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [BTN_W-1:0]  BUTTONS_IDLE   = 24'h000008;
    localparam logic [LEN_W-1:0]  MIN_REPORT     = 10'd10;
    localparam logic [TIME_W-1:0] DEFAULT_DELAY  = 32'd5000000;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_SUSPEND = 3'd1,
        OP_RESUME  = 3'd2,
        OP_CONNECT = 3'd3,
        OP_DISCON  = 3'd4,
        OP_REPORT  = 3'd5,
        OP_TAKE    = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_PENDING   = 2'd1,
        PH_REQUESTED = 2'd2,
        PH_DONE      = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAKE_ENABLE = 2'd0,
        CFG_RELEASE_DLY = 2'd1,
        CFG_REQ_TIMEOUT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic              wake_enable;
        logic [TIME_W-1:0] release_delay_us;
        logic [TIME_W-1:0] request_timeout_us;
    } t_cfg;

    typedef struct packed {
        logic              host_asleep;
        logic              host_woke;
        t_phase            wake_phase;
        logic [TIME_W-1:0] phase_start;
        logic              sleep_timer_armed;
        logic [TIME_W-1:0] sleep_start;
        logic              released_flag;
        logic              radio_wake_flag;
        logic [BTN_W-1:0]  last_buttons;
    } t_state;

    typedef struct packed {
        logic [2:0]        op;
        logic [TIME_W-1:0] time_us;
        logic              wake_accepted;
        logic [LEN_W-1:0]  report_length;
        logic [7:0]        buttons_a;
        logic [7:0]        buttons_b;
        logic [7:0]        buttons_c;
    } t_in_item;

    typedef struct packed {
        logic       wake_signal;
        logic       wake_forced;
        logic       release_link;
        logic       radio_quiet;
        logic       radio_wake_taken;
        logic       suspended_now;
        logic       link_released;
        logic [1:0] phase;
    } t_out_item;

endpackage

/* rtl/core/usbrw_in_if.sv */
`timescale 1ns / 1ps
// Event channel of the USB remote-wake controller: valid/ready plus event fields.
// Depends on usbrw_pkg for field widths.

interface usbrw_in_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    op;
    logic [usbrw_pkg::TIME_W-1:0]  time_us;
    logic                          wake_accepted;
    logic [usbrw_pkg::LEN_W-1:0]   report_length;
    logic [7:0]                    buttons_a;
    logic [7:0]                    buttons_b;
    logic [7:0]                    buttons_c;

    modport source (output valid, op, time_us, wake_accepted, report_length,
                    buttons_a, buttons_b, buttons_c, input ready);
    modport sink   (input valid, op, time_us, wake_accepted, report_length,
                    buttons_a, buttons_b, buttons_c, output ready);
endinterface

/* rtl/core/usbrw_out_if.sv */
`timescale 1ns / 1ps
// Result channel of the USB remote-wake controller: valid/ready plus status fields.
// No package dependency.

interface usbrw_out_if;
    logic       valid;
    logic       ready;
    logic       wake_signal;
    logic       wake_forced;
    logic       release_link;
    logic       radio_quiet;
    logic       radio_wake_taken;
    logic       suspended_now;
    logic       link_released;
    logic [1:0] phase;

    modport source (output valid, wake_signal, wake_forced, release_link, radio_quiet,
                    radio_wake_taken, suspended_now, link_released, phase, input ready);
    modport sink   (input valid, wake_signal, wake_forced, release_link, radio_quiet,
                    radio_wake_taken, suspended_now, link_released, phase, output ready);
endinterface

/* rtl/core/usbrw_step.sv */
`timescale 1ns / 1ps
// Next-state and result logic for one event of the remote-wake controller.
// Purely combinational; depends on usbrw_pkg.

module usbrw_step (
    input  usbrw_pkg::t_state    i_state,
    input  usbrw_pkg::t_cfg      i_cfg,
    input  usbrw_pkg::t_in_item  i_item,
    output usbrw_pkg::t_state    o_state,
    output usbrw_pkg::t_out_item o_result
);

    logic [usbrw_pkg::TIME_W-1:0] sleep_elapsed;
    logic [usbrw_pkg::TIME_W-1:0] phase_elapsed;
    logic [usbrw_pkg::BTN_W-1:0]  buttons;
    logic                         armable;
    logic                         sig;
    logic                         forced;
    logic                         rel;
    logic                         quiet;
    logic                         taken;
    usbrw_pkg::t_state            ns;

    assign sleep_elapsed = i_item.time_us - i_state.sleep_start;
    assign phase_elapsed = i_item.time_us - i_state.phase_start;
    assign buttons       = {i_item.buttons_c, i_item.buttons_b, i_item.buttons_a};
    assign armable       = (i_state.wake_phase != usbrw_pkg::PH_REQUESTED);

    always_comb begin
        ns     = i_state;
        sig    = 1'b0;
        forced = 1'b0;
        rel    = 1'b0;
        quiet  = 1'b0;
        taken  = 1'b0;
        case (usbrw_pkg::t_op'(i_item.op))
            usbrw_pkg::OP_TICK: begin
                if (i_state.sleep_timer_armed && i_state.host_asleep &&
                    !i_state.released_flag && sleep_elapsed >= i_cfg.release_delay_us) begin
                    ns.released_flag     = 1'b1;
                    ns.sleep_timer_armed = 1'b0;
                    rel                  = 1'b1;
                end
                if (i_state.wake_phase == usbrw_pkg::PH_PENDING) begin
                    if (!i_state.host_asleep) begin
                        ns.wake_phase  = usbrw_pkg::PH_DONE;
                        ns.phase_start = i_item.time_us;
                    end
                end else if (i_state.wake_phase == usbrw_pkg::PH_REQUESTED) begin
                    if (i_state.host_woke || !i_state.host_asleep ||
                        phase_elapsed > i_cfg.request_timeout_us) begin
                        ns.wake_phase  = usbrw_pkg::PH_DONE;
                        ns.phase_start = i_item.time_us;
                    end
                end
            end
            usbrw_pkg::OP_SUSPEND: begin
                ns.host_asleep       = 1'b1;
                ns.host_woke         = 1'b0;
                ns.sleep_start       = i_item.time_us;
                ns.sleep_timer_armed = 1'b1;
                ns.released_flag     = 1'b0;
                ns.wake_phase        = usbrw_pkg::PH_PENDING;
                ns.phase_start       = i_item.time_us;
                ns.last_buttons      = usbrw_pkg::BUTTONS_IDLE;
            end
            usbrw_pkg::OP_RESUME: begin
                if (i_state.released_flag) begin
                    ns.radio_wake_flag = 1'b1;
                end
                ns.host_asleep       = 1'b0;
                ns.host_woke         = 1'b1;
                ns.sleep_timer_armed = 1'b0;
                ns.released_flag     = 1'b0;
            end
            usbrw_pkg::OP_CONNECT: begin
                // requests only happen while asleep, so a refusal always forces
                if (i_state.host_asleep && armable && i_cfg.wake_enable) begin
                    ns.wake_phase  = usbrw_pkg::PH_REQUESTED;
                    ns.phase_start = i_item.time_us;
                    sig            = i_item.wake_accepted;
                    forced         = !i_item.wake_accepted;
                end
            end
            usbrw_pkg::OP_DISCON: begin
                ns.wake_phase   = usbrw_pkg::PH_IDLE;
                ns.last_buttons = usbrw_pkg::BUTTONS_IDLE;
                quiet = i_state.host_asleep && i_state.released_flag && !i_cfg.wake_enable;
            end
            usbrw_pkg::OP_REPORT: begin
                if (i_item.report_length >= usbrw_pkg::MIN_REPORT) begin
                    ns.last_buttons = buttons;
                    if ((buttons != i_state.last_buttons) && armable &&
                        i_state.host_asleep && i_cfg.wake_enable) begin
                        ns.wake_phase  = usbrw_pkg::PH_REQUESTED;
                        ns.phase_start = i_item.time_us;
                        sig            = i_item.wake_accepted;
                        forced         = !i_item.wake_accepted;
                    end
                end
            end
            usbrw_pkg::OP_TAKE: begin
                taken              = i_state.radio_wake_flag;
                ns.radio_wake_flag = 1'b0;
            end
            default: begin
                // undefined op: status only
            end
        endcase
    end

    assign o_state                   = ns;
    assign o_result.wake_signal      = sig;
    assign o_result.wake_forced      = forced;
    assign o_result.release_link     = rel;
    assign o_result.radio_quiet      = quiet;
    assign o_result.radio_wake_taken = taken;
    assign o_result.suspended_now    = ns.host_asleep;
    assign o_result.link_released    = ns.released_flag;
    assign o_result.phase            = ns.wake_phase;

endmodule

/* rtl/core/usb_remote_wake_controller_top.sv */
`timescale 1ns / 1ps
// USB remote-wake controller top level: event register, step logic, result register.
// Depends on usbrw_pkg, usbrw_in_if, usbrw_out_if and usbrw_step.
//
// Usage:
//   i_in carries timestamped events (tick, suspend, resume, connect, disconnect,
//   button report, take radio flag); o_out returns exactly one status item per
//   event, in order. Both channels move an item when valid and ready are high.
//   Configuration (wake enable, release delay, request timeout) is written via
//   i_cfg_we / i_cfg_index / i_cfg_data, by the user only while no events are in
//   flight; the block itself does not enforce this.
//   An accepted event waits in the event register; the step logic works on it and loads
//   the result register and the state once the result register can take it.
//   Throughput: one event per cycle while the receiver does not stall; the state
//   registers close a loop through the step logic.
//   Reset (synchronous, i_rst_n low) clears both pipeline stages, restores the
//   reset state (idle phase, idle buttons) and the default configuration.
//   When the receiver stalls, the result register holds and the event register
//   holds behind it; i_in.ready drops only once both stages are full.

module usb_remote_wake_controller_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    usbrw_in_if.sink                          i_in,
    usbrw_out_if.source                       o_out,
    input  logic                              i_cfg_we,
    input  logic [usbrw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [usbrw_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    logic                 r_in_valid;
    usbrw_pkg::t_in_item  r_in;
    logic                 r_out_valid;
    usbrw_pkg::t_out_item r_out;
    usbrw_pkg::t_state    r_state;
    usbrw_pkg::t_cfg      r_cfg;

    usbrw_pkg::t_state    n_state;
    usbrw_pkg::t_out_item n_out;
    logic                 adv;
    logic                 in_take;

    assign adv     = !r_out_valid || o_out.ready;
    assign in_take = i_in.valid && i_in.ready;

    assign i_in.ready = !r_in_valid || adv;

    usbrw_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.op            <= i_in.op;
            r_in.time_us       <= i_in.time_us;
            r_in.wake_accepted <= i_in.wake_accepted;
            r_in.report_length <= i_in.report_length;
            r_in.buttons_a     <= i_in.buttons_a;
            r_in.buttons_b     <= i_in.buttons_b;
            r_in.buttons_c     <= i_in.buttons_c;
        end
    end

    // result register and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid               <= 1'b0;
            r_state.host_asleep       <= 1'b0;
            r_state.host_woke         <= 1'b0;
            r_state.wake_phase        <= usbrw_pkg::PH_IDLE;
            r_state.phase_start       <= '0;
            r_state.sleep_timer_armed <= 1'b0;
            r_state.sleep_start       <= '0;
            r_state.released_flag     <= 1'b0;
            r_state.radio_wake_flag   <= 1'b0;
            r_state.last_buttons      <= usbrw_pkg::BUTTONS_IDLE;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wake_enable        <= 1'b1;
            r_cfg.release_delay_us   <= usbrw_pkg::DEFAULT_DELAY;
            r_cfg.request_timeout_us <= usbrw_pkg::DEFAULT_DELAY;
        end else if (i_cfg_we) begin
            case (usbrw_pkg::t_cfg_idx'(i_cfg_index))
                usbrw_pkg::CFG_WAKE_ENABLE: r_cfg.wake_enable        <= i_cfg_data[0];
                usbrw_pkg::CFG_RELEASE_DLY: r_cfg.release_delay_us   <= i_cfg_data;
                usbrw_pkg::CFG_REQ_TIMEOUT: r_cfg.request_timeout_us <= i_cfg_data;
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.wake_signal      = r_out.wake_signal;
    assign o_out.wake_forced      = r_out.wake_forced;
    assign o_out.release_link     = r_out.release_link;
    assign o_out.radio_quiet      = r_out.radio_quiet;
    assign o_out.radio_wake_taken = r_out.radio_wake_taken;
    assign o_out.suspended_now    = r_out.suspended_now;
    assign o_out.link_released    = r_out.link_released;
    assign o_out.phase            = r_out.phase;

    a_wake_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.wake_signal && r_out.wake_forced))
        else $error("wake signalled and forced in the same item");

    a_wake_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.wake_signal || r_out.wake_forced)) |->
        (r_out.phase == usbrw_pkg::PH_REQUESTED && r_out.suspended_now))
        else $error("wake pulse without a requested phase while suspended");

    a_release_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.release_link) |-> (r_out.link_released && r_out.suspended_now))
        else $error("link release ordered without the released flag");

    a_quiet_cond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.radio_quiet) |->
        (r_out.link_released && r_out.phase == usbrw_pkg::PH_IDLE && !r_cfg.wake_enable))
        else $error("radio quiet outside a released, wake-disabled disconnect");

endmodule

/* dv/usbrw_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the USB remote-wake controller: mirrors its state and configuration,
// predicts one status item per event and compares it with the result channel.
// Depends on usbrw_pkg, usbrw_in_if and usbrw_out_if.

module usbrw_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    usbrw_in_if                             i_ev,
    usbrw_out_if                            i_res,
    input  logic                            i_cfg_we,
    input  logic [usbrw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [usbrw_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_wakes,
    output int                              o_releases,
    output int                              o_quiets
);
    import usbrw_pkg::*;

    t_cfg      cfg;
    t_state    st;
    t_out_item status_q[$];
    int        err_cnt;
    int        res_cnt;
    int        wake_cnt;
    int        rel_cnt;
    int        quiet_cnt;

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic compare_field(input string name, input logic [1:0] got,
                                 input logic [1:0] want);
        if (got !== want) begin
            report_error($sformatf("result %0d %s got %0d expected %0d",
                                   res_cnt, name, got, want));
        end
    endtask

    // Wake is only ever attempted while asleep; a refusal then forces it.
    task automatic attempt_wake(input logic [TIME_W-1:0] t, input logic acc,
                                inout t_out_item r);
        if (cfg.wake_enable) begin
            if (acc) begin
                st.wake_phase  = PH_REQUESTED;
                st.phase_start = t;
                r.wake_signal  = 1'b1;
            end else if (st.host_asleep) begin
                st.wake_phase  = PH_REQUESTED;
                st.phase_start = t;
                r.wake_forced  = 1'b1;
            end
        end
    endtask

    task automatic predict_status(input t_in_item ev, output t_out_item r);
        logic [BTN_W-1:0]  btn;
        logic [TIME_W-1:0] sleep_age;
        logic [TIME_W-1:0] req_age;
        logic              changed;
        logic              armable;
        btn       = {ev.buttons_c, ev.buttons_b, ev.buttons_a};
        sleep_age = ev.time_us - st.sleep_start;
        req_age   = ev.time_us - st.phase_start;
        armable   = (st.wake_phase != PH_REQUESTED);
        r = '0;
        case (ev.op)
            OP_TICK: begin
                if (st.sleep_timer_armed && st.host_asleep && !st.released_flag &&
                    sleep_age >= cfg.release_delay_us) begin
                    st.released_flag     = 1'b1;
                    st.sleep_timer_armed = 1'b0;
                    r.release_link       = 1'b1;
                end
                if (st.wake_phase == PH_PENDING) begin
                    if (!st.host_asleep) begin
                        st.wake_phase  = PH_DONE;
                        st.phase_start = ev.time_us;
                    end
                end else if (st.wake_phase == PH_REQUESTED) begin
                    if (st.host_woke || !st.host_asleep || req_age > cfg.request_timeout_us) begin
                        st.wake_phase  = PH_DONE;
                        st.phase_start = ev.time_us;
                    end
                end
            end
            OP_SUSPEND: begin
                st.host_asleep       = 1'b1;
                st.host_woke         = 1'b0;
                st.sleep_start       = ev.time_us;
                st.sleep_timer_armed = 1'b1;
                st.released_flag     = 1'b0;
                st.wake_phase        = PH_PENDING;
                st.phase_start       = ev.time_us;
                st.last_buttons      = BUTTONS_IDLE;
            end
            OP_RESUME: begin
                if (st.released_flag) begin
                    st.radio_wake_flag = 1'b1;
                end
                st.host_asleep       = 1'b0;
                st.host_woke         = 1'b1;
                st.sleep_timer_armed = 1'b0;
                st.released_flag     = 1'b0;
            end
            OP_CONNECT: begin
                if (st.host_asleep && armable) begin
                    attempt_wake(ev.time_us, ev.wake_accepted, r);
                end
            end
            OP_DISCON: begin
                st.wake_phase   = PH_IDLE;
                st.last_buttons = BUTTONS_IDLE;
                if (st.host_asleep && st.released_flag && !cfg.wake_enable) begin
                    r.radio_quiet = 1'b1;
                end
            end
            OP_REPORT: begin
                if (ev.report_length >= MIN_REPORT) begin
                    changed         = (btn != st.last_buttons);
                    st.last_buttons = btn;
                    if (changed && armable && st.host_asleep) begin
                        attempt_wake(ev.time_us, ev.wake_accepted, r);
                    end
                end
            end
            OP_TAKE: begin
                r.radio_wake_taken = st.radio_wake_flag;
                st.radio_wake_flag = 1'b0;
            end
            default: begin
                // undefined opcode: status only
            end
        endcase
        r.suspended_now = st.host_asleep;
        r.link_released = st.released_flag;
        r.phase         = st.wake_phase;
    endtask

    always @(posedge i_clk) begin : scoreboard_step
        t_in_item  ev;
        t_out_item want;
        if (!i_rst_n) begin
            cfg.wake_enable        = 1'b1;
            cfg.release_delay_us   = DEFAULT_DELAY;
            cfg.request_timeout_us = DEFAULT_DELAY;
            st                     = '0;
            st.wake_phase          = PH_IDLE;
            st.last_buttons        = BUTTONS_IDLE;
            status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WAKE_ENABLE: cfg.wake_enable        = i_cfg_data[0];
                    CFG_RELEASE_DLY: cfg.release_delay_us   = i_cfg_data;
                    CFG_REQ_TIMEOUT: cfg.request_timeout_us = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (status_q.size() == 0) begin
                    report_error($sformatf("result %0d arrived with no event outstanding",
                                           res_cnt));
                end else begin
                    want = status_q.pop_front();
                    compare_field("wake_signal", i_res.wake_signal, want.wake_signal);
                    compare_field("wake_forced", i_res.wake_forced, want.wake_forced);
                    compare_field("release_link", i_res.release_link, want.release_link);
                    compare_field("radio_quiet", i_res.radio_quiet, want.radio_quiet);
                    compare_field("radio_wake_taken", i_res.radio_wake_taken,
                                  want.radio_wake_taken);
                    compare_field("suspended_now", i_res.suspended_now, want.suspended_now);
                    compare_field("link_released", i_res.link_released, want.link_released);
                    compare_field("phase", i_res.phase, want.phase);
                    wake_cnt  += want.wake_signal + want.wake_forced;
                    rel_cnt   += want.release_link;
                    quiet_cnt += want.radio_quiet;
                end
                res_cnt++;
            end
            if (i_ev.valid && i_ev.ready) begin
                ev.op            = i_ev.op;
                ev.time_us       = i_ev.time_us;
                ev.wake_accepted = i_ev.wake_accepted;
                ev.report_length = i_ev.report_length;
                ev.buttons_a     = i_ev.buttons_a;
                ev.buttons_b     = i_ev.buttons_b;
                ev.buttons_c     = i_ev.buttons_c;
                predict_status(ev, want);
                status_q.push_back(want);
            end
        end
        o_errors   <= err_cnt;
        o_pending  <= status_q.size();
        o_results  <= res_cnt;
        o_wakes    <= wake_cnt;
        o_releases <= rel_cnt;
        o_quiets   <= quiet_cnt;
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Top of the USB remote-wake controller testbench: clock, reset, event stimulus,
// result-side stalls and the verdict. Depends on usbrw_pkg, the channel interfaces,
// usb_remote_wake_controller_top and usbrw_checker.

module testbench;
    import usbrw_pkg::*;

    localparam int               LIMIT_CYCLES = 400000;
    localparam int               HOLD_CYCLES  = 300;
    localparam logic [2:0]       OP_UNDEFINED = 3'd7;
    localparam logic [LEN_W-1:0] LEN_MAX      = 10'h3FF;
    localparam logic [TIME_W-1:0] TIME_MAX    = 32'hFFFF_FFFF;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    usbrw_in_if  ev_ch ();
    usbrw_out_if res_ch ();

    int          errors;
    int          pending;
    int          results;
    int          wakes;
    int          releases;
    int          quiets;
    int unsigned idle_pct;
    int unsigned stall_pct;
    logic        pressure_on;
    int          hold_count;
    int unsigned sent;
    int          cycle_count;
    logic [TIME_W-1:0] now_us;
    logic [BTN_W-1:0]  last_btn;

    always #4 clk = ~clk;

    usb_remote_wake_controller_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (ev_ch),
        .o_out       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    usbrw_checker scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_ev        (ev_ch),
        .i_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_wakes     (wakes),
        .o_releases  (releases),
        .o_quiets    (quiets)
    );

    // Result side: random stalls, plus a long hold at the start of a pressure phase.
    always @(posedge clk) begin
        if (!pressure_on) begin
            hold_count <= 0;
        end else if (hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
        end
        res_ch.ready <= !(pressure_on && hold_count < HOLD_CYCLES) &&
                        ($urandom_range(99) >= stall_pct);
    end

    task automatic send_event(input logic [2:0] op, input logic [TIME_W-1:0] t,
                              input logic acc, input logic [LEN_W-1:0] len,
                              input logic [BTN_W-1:0] btn);
        while ($urandom_range(99) < idle_pct) begin
            ev_ch.valid <= 1'b0;
            @(posedge clk);
        end
        ev_ch.valid         <= 1'b1;
        ev_ch.op            <= op;
        ev_ch.time_us       <= t;
        ev_ch.wake_accepted <= acc;
        ev_ch.report_length <= len;
        ev_ch.buttons_a     <= btn[7:0];
        ev_ch.buttons_b     <= btn[15:8];
        ev_ch.buttons_c     <= btn[23:16];
        @(posedge clk);
        while (!ev_ch.ready) @(posedge clk);
        sent++;
    endtask

    // Drop valid and hold until every expected status item is back.
    task automatic drain();
        ev_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic wake_en, input logic [TIME_W-1:0] rel_dly,
                            input logic [TIME_W-1:0] req_tmo);
        write_reg(CFG_WAKE_ENABLE, {{(CFG_DAT_W-1){1'b0}}, wake_en});
        write_reg(CFG_RELEASE_DLY, rel_dly);
        write_reg(CFG_REQ_TIMEOUT, req_tmo);
    endtask

    // Advance time (now and then jump anywhere) and send one event of the given op.
    task automatic random_event(input logic [2:0] op, input int unsigned step_max);
        logic [LEN_W-1:0] len;
        logic [BTN_W-1:0] btn;
        int unsigned      pick;
        if ($urandom_range(99) < 3) begin
            now_us = $urandom();
        end else begin
            now_us = now_us + $urandom_range(step_max);
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            len = LEN_W'($urandom_range(MIN_REPORT - 1));
        end else if (pick < 15) begin
            len = (pick < 12) ? MIN_REPORT : LEN_MAX;
        end else begin
            len = LEN_W'($urandom_range(LEN_MAX, MIN_REPORT));
        end
        pick = $urandom_range(99);
        if (pick < 35) begin
            btn = last_btn;
        end else if (pick < 50) begin
            btn = BUTTONS_IDLE;
        end else begin
            btn = BTN_W'($urandom());
        end
        if (op == OP_REPORT && len >= MIN_REPORT) begin
            last_btn = btn;
        end else if (op == OP_SUSPEND || op == OP_DISCON) begin
            last_btn = BUTTONS_IDLE;
        end
        send_event(op, now_us, 1'($urandom_range(1)), len, btn);
    endtask

    // Suspend, a burst of activity while asleep, usually a resume, then some noise.
    task automatic run_episodes(input int unsigned count, input int unsigned step_max);
        int unsigned target;
        int unsigned pick;
        logic [2:0]  op;
        target = sent + count;
        while (sent < target) begin
            random_event(OP_SUSPEND, step_max);
            repeat ($urandom_range(12, 2)) begin
                pick = $urandom_range(99);
                if (pick < 40)      op = OP_TICK;
                else if (pick < 75) op = OP_REPORT;
                else if (pick < 85) op = OP_CONNECT;
                else if (pick < 90) op = OP_DISCON;
                else if (pick < 95) op = OP_TAKE;
                else                op = OP_UNDEFINED;
                random_event(op, step_max);
            end
            if ($urandom_range(99) < 85) begin
                random_event(OP_RESUME, step_max);
            end
            repeat ($urandom_range(3)) begin
                op = 3'($urandom_range(7));
                random_event(op, step_max);
            end
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run did not complete within %0d cycles", LIMIT_CYCLES);
        $display("FAILURE");
        $finish;
    end

    initial begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_WAKE_ENABLE;
        cfg_data            <= '0;
        ev_ch.valid         <= 1'b0;
        ev_ch.op            <= OP_TICK;
        ev_ch.time_us       <= '0;
        ev_ch.wake_accepted <= 1'b0;
        ev_ch.report_length <= '0;
        ev_ch.buttons_a     <= '0;
        ev_ch.buttons_b     <= '0;
        ev_ch.buttons_c     <= '0;
        pressure_on         <= 1'b0;
        stall_pct           <= 0;
        idle_pct  = 0;
        sent      = 0;
        now_us    = '0;
        last_btn  = BUTTONS_IDLE;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers: boundaries of release and timeout, both wake paths.
        send_event(OP_TAKE, 32'd0, 1'b0, '0, BUTTONS_IDLE);
        send_event(OP_UNDEFINED, TIME_MAX, 1'b1, LEN_MAX, 24'hFFFFFF);
        send_event(OP_REPORT, 32'd10, 1'b1, MIN_REPORT - 10'd1, 24'h123456);
        send_event(OP_REPORT, 32'd20, 1'b1, MIN_REPORT, 24'hABCDEF);
        send_event(OP_CONNECT, 32'd30, 1'b1, '0, '0);
        send_event(OP_SUSPEND, 32'd100, 1'b0, '0, '0);
        send_event(OP_REPORT, 32'd150, 1'b1, LEN_MAX, BUTTONS_IDLE);
        send_event(OP_REPORT, 32'd200, 1'b1, MIN_REPORT, 24'hFFFFFF);
        send_event(OP_REPORT, 32'd210, 1'b0, MIN_REPORT, 24'h000000);
        send_event(OP_TICK, 32'd5000099, 1'b0, '0, '0);
        send_event(OP_TICK, 32'd5000100, 1'b0, '0, '0);
        send_event(OP_TICK, 32'd5000200, 1'b0, '0, '0);
        send_event(OP_TICK, 32'd5000201, 1'b0, '0, '0);
        send_event(OP_DISCON, 32'd5000300, 1'b0, '0, '0);
        send_event(OP_CONNECT, 32'd5000400, 1'b0, '0, '0);
        send_event(OP_RESUME, 32'd5000500, 1'b0, '0, '0);
        send_event(OP_TICK, 32'd5000600, 1'b0, '0, '0);
        send_event(OP_TAKE, 32'd5000700, 1'b0, '0, '0);
        send_event(OP_TAKE, 32'd5000800, 1'b0, '0, '0);
        send_event(OP_SUSPEND, 32'hFFFF_FFF0, 1'b0, '0, '0);
        send_event(OP_TICK, 32'h0000_0010, 1'b0, '0, '0);
        send_event(OP_REPORT, 32'h0000_0020, 1'b1, '0, 24'hFFFFFF);
        send_event(OP_CONNECT, 32'h0000_0030, 1'b1, '0, '0);
        send_event(OP_RESUME, 32'h0000_0040, 1'b0, '0, '0);
        send_event(OP_TICK, 32'h0000_0050, 1'b0, '0, '0);
        drain();

        // Wake off, zero delays: immediate release, radio quiet, dropped requests.
        set_regs(1'b0, '0, '0);
        send_event(OP_SUSPEND, 32'd1000, 1'b1, '0, '0);
        send_event(OP_TICK, 32'd1000, 1'b1, '0, '0);
        send_event(OP_DISCON, 32'd1001, 1'b1, '0, '0);
        send_event(OP_REPORT, 32'd1002, 1'b1, MIN_REPORT, 24'h5A5A5A);
        send_event(OP_CONNECT, 32'd1003, 1'b0, '0, '0);
        send_event(OP_RESUME, 32'd1004, 1'b0, '0, '0);
        drain();

        write_reg(CFG_WAKE_ENABLE, 32'd1);
        run_episodes(400, 50);
        drain();

        set_regs(1'b1, 32'd200, 32'd300);
        idle_pct = 83;
        run_episodes(350, 60);
        drain();

        set_regs(1'b0, 32'd50, 32'd20);
        idle_pct = 0;
        stall_pct <= 83;
        run_episodes(300, 20);
        drain();

        set_regs(1'b1, TIME_MAX, TIME_MAX);
        idle_pct = 18;
        stall_pct <= 18;
        run_episodes(200, 32'h1000_0000);
        drain();
        run_episodes(150, 32'h1000_0000);
        drain();

        // Hold the result side off while events keep coming, so the input backs up.
        set_regs(1'b1, 32'd1000, 32'd500);
        idle_pct = 0;
        stall_pct <= 0;
        pressure_on <= 1'b1;
        run_episodes(200, 300);
        pressure_on <= 1'b0;
        drain();
        repeat (8) @(posedge clk);

        $display("Sent %0d events: directed boundaries, wake on/off, zero and full-scale delays,",
                 sent);
        $display("idle/stall mixes and a long result hold; %0d results, %0d wakes,",
                 results, wakes);
        $display("%0d releases, %0d quiets.", releases, quiets);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
